// ----- design/iemh_pkg.sv -----
// Package for the indexed edge min-heap: request/response and key types,
// operation and status codes, controller/datapath interface and key compare.
// No dependencies.
`default_nettype none

package iemh_pkg;

    localparam int MAX_EDGES_DEF = 256;
    localparam int ID_SPACE      = 256;
    localparam int COUNT_W       = 9;

    // Operation codes
    localparam logic [2:0] FUNC_INSERT    = 3'd0;
    localparam logic [2:0] FUNC_REM_FRONT = 3'd1;
    localparam logic [2:0] FUNC_REM_EDGE  = 3'd2;
    localparam logic [2:0] FUNC_UPDATE    = 3'd3;
    localparam logic [2:0] FUNC_APPEND    = 3'd4;
    localparam logic [2:0] FUNC_BUILD     = 3'd5;
    localparam logic [2:0] FUNC_READ      = 3'd6;
    localparam logic [2:0] FUNC_UNUSED    = 3'd7;

    // Status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FULL  = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_EDGE  = 3'd3;
    localparam logic [2:0] ST_SLOT  = 3'd4;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  edge_id;
        logic [31:0] weight;
        logic [19:0] area_a;
        logic [19:0] area_b;
        logic [11:0] first_x;
        logic [11:0] first_y;
        logic [11:0] second_x;
        logic [11:0] second_y;
        logic [7:0]  slot;
    } request_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               front_valid;
        logic [7:0]         front_id;
        logic [COUNT_W-1:0] count;
        logic [7:0]         read_id;
    } response_t;

    typedef struct packed {
        logic [31:0] weight;
        logic [19:0] area_a;
        logic [19:0] area_b;
        logic [11:0] first_x;
        logic [11:0] first_y;
        logic [11:0] second_x;
        logic [11:0] second_y;
    } key_t;

    // Controller to datapath: one action flag per sequencer step
    typedef struct packed {
        logic load;
        logic dec;
        logic rm_pos;
        logic upd_pos;
        logic rm_chk;
        logic ld_id;
        logic ld_key;
        logic up_rd;
        logic up_pid;
        logic up_cmp;
        logic dn_l;
        logic dn_r;
        logic dn_lk;
        logic dn_rk;
        logic dn_cmp;
        logic place;
        logic bld_next;
        logic rd_wait;
        logic done;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] func;
        logic       hit;
        logic       full;
        logic       empty;
        logic       oob;
        logic       last;
        logic       pos_zero;
        logic       l_oob;
        logic       up_swap;
        logic       has_r;
        logic       dn_move;
        logic       bidx_zero;
    } sts_t;

    // True when key p must stand behind key q
    function automatic logic goes_after(key_t p, key_t q);
        logic [19:0] pmax, pmin, qmax, qmin;
        logic [23:0] pa, pb, qa, qb, plo, phi, qlo, qhi;
        logic        res;
        pmax = (p.area_a > p.area_b) ? p.area_a : p.area_b;
        pmin = (p.area_a < p.area_b) ? p.area_a : p.area_b;
        qmax = (q.area_a > q.area_b) ? q.area_a : q.area_b;
        qmin = (q.area_a < q.area_b) ? q.area_a : q.area_b;
        pa = {p.first_x, p.first_y};
        pb = {p.second_x, p.second_y};
        qa = {q.first_x, q.first_y};
        qb = {q.second_x, q.second_y};
        plo = (pa < pb) ? pa : pb;
        phi = (pa < pb) ? pb : pa;
        qlo = (qa < qb) ? qa : qb;
        qhi = (qa < qb) ? qb : qa;
        if (p.weight != q.weight)
            res = p.weight > q.weight;
        else if (pmax != qmax)
            res = pmax > qmax;
        else if (pmin != qmin)
            res = pmin > qmin;
        else if (plo != qlo)
            res = plo > qlo;
        else
            res = phi > qhi;
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- design/iemh_ctrl.sv -----
// Sequencer for the indexed edge min-heap: steps each request through
// decode, sift-up, sift-down and heap build. Depends on iemh_pkg.
`default_nettype none

module iemh_ctrl
    import iemh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    output logic      done,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DEC      = 5'd1;
    localparam logic [4:0] S_RM_POS   = 5'd2;
    localparam logic [4:0] S_UPD_POS  = 5'd3;
    localparam logic [4:0] S_RM_CHK   = 5'd4;
    localparam logic [4:0] S_LD_ID    = 5'd5;
    localparam logic [4:0] S_LD_KEY   = 5'd6;
    localparam logic [4:0] S_UP_RD    = 5'd7;
    localparam logic [4:0] S_UP_PID   = 5'd8;
    localparam logic [4:0] S_UP_CMP   = 5'd9;
    localparam logic [4:0] S_DN_L     = 5'd10;
    localparam logic [4:0] S_DN_R     = 5'd11;
    localparam logic [4:0] S_DN_LK    = 5'd12;
    localparam logic [4:0] S_DN_RK    = 5'd13;
    localparam logic [4:0] S_DN_CMP   = 5'd14;
    localparam logic [4:0] S_PLACE    = 5'd15;
    localparam logic [4:0] S_BLD_NEXT = 5'd16;
    localparam logic [4:0] S_RD_WAIT  = 5'd17;
    localparam logic [4:0] S_DONE     = 5'd18;

    logic [4:0] state_reg, state_next;
    logic       try_dn_reg, try_dn_next;
    logic       bld_reg, bld_next;

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        try_dn_next = try_dn_reg;
        bld_next    = bld_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next  = S_DEC;
                    try_dn_next = 1'b0;
                    bld_next    = 1'b0;
                end
            end
            S_DEC:
            begin
                case (sts.func)
                    FUNC_INSERT, FUNC_APPEND:
                    begin
                        if (sts.hit || sts.full)
                            state_next = S_DONE;
                        else if (sts.func == FUNC_APPEND)
                            state_next = S_PLACE;
                        else
                            state_next = S_UP_RD;
                    end
                    FUNC_REM_FRONT:
                        state_next = sts.empty ? S_DONE : S_RM_CHK;
                    FUNC_REM_EDGE:
                        state_next = sts.hit ? S_RM_POS : S_DONE;
                    FUNC_UPDATE:
                        state_next = sts.hit ? S_UPD_POS : S_DONE;
                    FUNC_BUILD:
                    begin
                        bld_next   = 1'b1;
                        state_next = S_BLD_NEXT;
                    end
                    FUNC_READ:
                        state_next = sts.oob ? S_DONE : S_RD_WAIT;
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_RM_POS:
                state_next = S_RM_CHK;
            S_UPD_POS:
            begin
                try_dn_next = 1'b1;
                state_next  = S_UP_RD;
            end
            S_RM_CHK:
                state_next = sts.last ? S_DONE : S_LD_ID;
            S_LD_ID:
                state_next = S_LD_KEY;
            S_LD_KEY:
            begin
                if (bld_reg)
                    state_next = S_DN_L;
                else
                begin
                    try_dn_next = 1'b1;
                    state_next  = S_UP_RD;
                end
            end
            S_UP_RD:
            begin
                if (!sts.pos_zero)
                    state_next = S_UP_PID;
                else
                    state_next = try_dn_reg ? S_DN_L : S_PLACE;
            end
            S_UP_PID:
                state_next = S_UP_CMP;
            S_UP_CMP:
            begin
                if (sts.up_swap)
                begin
                    try_dn_next = 1'b0;
                    state_next  = S_UP_RD;
                end
                else
                    state_next = try_dn_reg ? S_DN_L : S_PLACE;
            end
            S_DN_L:
                state_next = sts.l_oob ? S_PLACE : S_DN_R;
            S_DN_R:
                state_next = S_DN_LK;
            S_DN_LK:
                state_next = sts.has_r ? S_DN_RK : S_DN_CMP;
            S_DN_RK:
                state_next = S_DN_CMP;
            S_DN_CMP:
                state_next = (sts.dn_move && sts.has_r) ? S_DN_L : S_PLACE;
            S_PLACE:
                state_next = bld_reg ? S_BLD_NEXT : S_DONE;
            S_BLD_NEXT:
                state_next = sts.bidx_zero ? S_DONE : S_LD_ID;
            S_RD_WAIT:
                state_next = S_DONE;
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Step commands
    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == S_IDLE) && start;
        cmd.dec      = state_reg == S_DEC;
        cmd.rm_pos   = state_reg == S_RM_POS;
        cmd.upd_pos  = state_reg == S_UPD_POS;
        cmd.rm_chk   = state_reg == S_RM_CHK;
        cmd.ld_id    = state_reg == S_LD_ID;
        cmd.ld_key   = state_reg == S_LD_KEY;
        cmd.up_rd    = state_reg == S_UP_RD;
        cmd.up_pid   = state_reg == S_UP_PID;
        cmd.up_cmp   = state_reg == S_UP_CMP;
        cmd.dn_l     = state_reg == S_DN_L;
        cmd.dn_r     = state_reg == S_DN_R;
        cmd.dn_lk    = state_reg == S_DN_LK;
        cmd.dn_rk    = state_reg == S_DN_RK;
        cmd.dn_cmp   = state_reg == S_DN_CMP;
        cmd.place    = state_reg == S_PLACE;
        cmd.bld_next = state_reg == S_BLD_NEXT;
        cmd.rd_wait  = state_reg == S_RD_WAIT;
        cmd.done     = state_reg == S_DONE;
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_DONE;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            try_dn_reg <= 1'b0;
            bld_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            try_dn_reg <= try_dn_next;
            bld_reg    <= bld_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/iemh_datapath.sv -----
// Datapath for the indexed edge min-heap: slot, position and key memories,
// presence bits, count and the sift registers with the key comparators.
// Depends on iemh_pkg.
`default_nettype none

module iemh_datapath
    import iemh_pkg::*;
#(
    parameter int MAX_EDGES = MAX_EDGES_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire request_t req,
    input  wire cmd_t     cmd,
    output sts_t          sts,
    output response_t     rsp
);

    localparam int SW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW  = $clog2(MAX_EDGES + 1);
    localparam int CHW = CW + 1;

    // Memories
    logic [7:0]    slot_mem_reg [MAX_EDGES];
    logic [SW-1:0] pos_mem_reg  [ID_SPACE];
    key_t          key_mem_reg  [ID_SPACE];

    logic [7:0]    slot_rd_reg;
    logic [SW-1:0] pos_rd_reg;
    key_t          key_rd_reg;

    logic          slot_we, slot_re, pos_we, pos_re, key_we, key_re;
    logic [SW-1:0] slot_wa, slot_ra;
    logic [7:0]    slot_wd, pos_wa, pos_ra, key_wa, key_ra;
    logic [SW-1:0] pos_wd;
    key_t          key_wd;

    // Control and sift registers
    request_t      req_reg, req_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] bidx_reg, bidx_next;
    logic [SW-1:0] pos_reg, pos_next;
    logic [ID_SPACE-1:0] present_reg, present_next;
    logic [7:0]    front_reg, front_next;
    logic [2:0]    status_reg, status_next;
    logic [7:0]    read_id_reg, read_id_next;
    logic          has_r_reg, has_r_next;
    logic [7:0]    e_id_reg, e_id_next, l_id_reg, l_id_next, r_id_reg, r_id_next;
    key_t          e_key_reg, e_key_next, l_key_reg, l_key_next, r_key_reg, r_key_next;

    key_t           req_key;
    logic [SW-1:0]  parent;
    logic [CHW-1:0] lc, rc;
    logic           el, er, lr, pick_r;

    assign req_key = '{weight: req_reg.weight, area_a: req_reg.area_a,
                       area_b: req_reg.area_b, first_x: req_reg.first_x,
                       first_y: req_reg.first_y, second_x: req_reg.second_x,
                       second_y: req_reg.second_y};

    assign parent = (pos_reg - SW'(1)) >> 1;
    assign lc     = (CHW'(pos_reg) << 1) + CHW'(1);
    assign rc     = lc + CHW'(1);

    // Key compares for the sift-down step
    assign el     = goes_after(e_key_reg, l_key_reg);
    assign er     = goes_after(e_key_reg, r_key_reg);
    assign lr     = goes_after(l_key_reg, r_key_reg);
    assign pick_r = has_r_reg && lr;

    // Status to the controller
    always_comb
    begin
        sts           = '0;
        sts.func      = req_reg.func;
        sts.hit       = present_reg[req_reg.edge_id];
        sts.full      = 32'(cnt_reg) >= MAX_EDGES;
        sts.empty     = cnt_reg == '0;
        sts.oob       = 32'(req_reg.slot) >= 32'(cnt_reg);
        sts.last      = CW'(pos_reg) == (cnt_reg - CW'(1));
        sts.pos_zero  = pos_reg == '0;
        sts.l_oob     = lc >= CHW'(cnt_reg);
        sts.up_swap   = goes_after(key_rd_reg, e_key_reg);
        sts.has_r     = has_r_reg;
        sts.dn_move   = has_r_reg ? (el || er) : el;
        sts.bidx_zero = bidx_reg == '0;
    end

    // Step actions
    always_comb
    begin
        req_next     = req_reg;
        cnt_next     = cnt_reg;
        bidx_next    = bidx_reg;
        pos_next     = pos_reg;
        present_next = present_reg;
        status_next  = status_reg;
        read_id_next = read_id_reg;
        has_r_next   = has_r_reg;
        e_id_next    = e_id_reg;
        l_id_next    = l_id_reg;
        r_id_next    = r_id_reg;
        e_key_next   = e_key_reg;
        l_key_next   = l_key_reg;
        r_key_next   = r_key_reg;
        slot_we = 1'b0; slot_wa = '0; slot_wd = '0;
        slot_re = 1'b0; slot_ra = '0;
        pos_we  = 1'b0; pos_wa  = '0; pos_wd  = '0;
        pos_re  = 1'b0; pos_ra  = '0;
        key_we  = 1'b0; key_wa  = '0; key_wd  = '0;
        key_re  = 1'b0; key_ra  = '0;

        if (cmd.load)
        begin
            req_next     = req;
            status_next  = ST_OK;
            read_id_next = '0;
        end

        if (cmd.dec)
        begin
            case (req_reg.func)
                FUNC_INSERT, FUNC_APPEND:
                begin
                    if (sts.hit)
                        status_next = ST_EDGE;
                    else if (sts.full)
                        status_next = ST_FULL;
                    else
                    begin
                        key_we = 1'b1;
                        key_wa = req_reg.edge_id;
                        key_wd = req_key;
                        present_next[req_reg.edge_id] = 1'b1;
                        e_id_next  = req_reg.edge_id;
                        e_key_next = req_key;
                        pos_next   = SW'(cnt_reg);
                        cnt_next   = cnt_reg + CW'(1);
                    end
                end
                FUNC_REM_FRONT:
                begin
                    if (sts.empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        present_next[front_reg] = 1'b0;
                        pos_next = '0;
                    end
                end
                FUNC_REM_EDGE:
                begin
                    if (!sts.hit)
                        status_next = ST_EDGE;
                    else
                    begin
                        present_next[req_reg.edge_id] = 1'b0;
                        pos_re = 1'b1;
                        pos_ra = req_reg.edge_id;
                    end
                end
                FUNC_UPDATE:
                begin
                    if (!sts.hit)
                        status_next = ST_EDGE;
                    else
                    begin
                        key_we = 1'b1;
                        key_wa = req_reg.edge_id;
                        key_wd = req_key;
                        e_id_next  = req_reg.edge_id;
                        e_key_next = req_key;
                        pos_re = 1'b1;
                        pos_ra = req_reg.edge_id;
                    end
                end
                FUNC_BUILD:
                    bidx_next = cnt_reg >> 1;
                FUNC_READ:
                begin
                    if (sts.oob)
                        status_next = ST_SLOT;
                    else
                    begin
                        slot_re = 1'b1;
                        slot_ra = SW'(req_reg.slot);
                    end
                end
                default:
                    status_next = ST_OK;
            endcase
        end

        if (cmd.rm_pos || cmd.upd_pos)
            pos_next = pos_rd_reg;

        // Drop the last slot; fetch its edge unless it is the one removed
        if (cmd.rm_chk)
        begin
            cnt_next = cnt_reg - CW'(1);
            if (!sts.last)
            begin
                slot_re = 1'b1;
                slot_ra = SW'(cnt_reg - CW'(1));
            end
        end

        if (cmd.ld_id)
        begin
            e_id_next = slot_rd_reg;
            key_re    = 1'b1;
            key_ra    = slot_rd_reg;
        end
        if (cmd.ld_key)
            e_key_next = key_rd_reg;

        // Sift up: fetch parent, compare, move parent down into the hole
        if (cmd.up_rd && !sts.pos_zero)
        begin
            slot_re = 1'b1;
            slot_ra = parent;
        end
        if (cmd.up_pid)
        begin
            l_id_next = slot_rd_reg;
            key_re    = 1'b1;
            key_ra    = slot_rd_reg;
        end
        if (cmd.up_cmp && sts.up_swap)
        begin
            slot_we  = 1'b1;
            slot_wa  = pos_reg;
            slot_wd  = l_id_reg;
            pos_we   = 1'b1;
            pos_wa   = l_id_reg;
            pos_wd   = pos_reg;
            pos_next = parent;
        end

        // Sift down: fetch the children and their keys, move the smaller child up
        if (cmd.dn_l && !sts.l_oob)
        begin
            slot_re = 1'b1;
            slot_ra = SW'(lc);
        end
        if (cmd.dn_r)
        begin
            l_id_next  = slot_rd_reg;
            key_re     = 1'b1;
            key_ra     = slot_rd_reg;
            has_r_next = rc < CHW'(cnt_reg);
            if (rc < CHW'(cnt_reg))
            begin
                slot_re = 1'b1;
                slot_ra = SW'(rc);
            end
        end
        if (cmd.dn_lk)
        begin
            l_key_next = key_rd_reg;
            if (has_r_reg)
            begin
                r_id_next = slot_rd_reg;
                key_re    = 1'b1;
                key_ra    = slot_rd_reg;
            end
        end
        if (cmd.dn_rk)
            r_key_next = key_rd_reg;
        if (cmd.dn_cmp && sts.dn_move)
        begin
            slot_we  = 1'b1;
            slot_wa  = pos_reg;
            slot_wd  = pick_r ? r_id_reg : l_id_reg;
            pos_we   = 1'b1;
            pos_wa   = pick_r ? r_id_reg : l_id_reg;
            pos_wd   = pos_reg;
            pos_next = pick_r ? SW'(rc) : SW'(lc);
        end

        // Settle the moving edge into the hole
        if (cmd.place)
        begin
            slot_we = 1'b1;
            slot_wa = pos_reg;
            slot_wd = e_id_reg;
            pos_we  = 1'b1;
            pos_wa  = e_id_reg;
            pos_wd  = pos_reg;
        end

        // Advance heap build to the next internal slot
        if (cmd.bld_next && !sts.bidx_zero)
        begin
            bidx_next = bidx_reg - CW'(1);
            pos_next  = SW'(bidx_reg - CW'(1));
            slot_re   = 1'b1;
            slot_ra   = SW'(bidx_reg - CW'(1));
        end

        if (cmd.rd_wait)
            read_id_next = slot_rd_reg;
    end

    // Track the edge in slot 0
    assign front_next = (slot_we && slot_wa == '0) ? slot_wd : front_reg;

    // Memories
    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem_reg[slot_wa] <= slot_wd;
        if (slot_re)
            slot_rd_reg <= slot_mem_reg[slot_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem_reg[pos_wa] <= pos_wd;
        if (pos_re)
            pos_rd_reg <= pos_mem_reg[pos_ra];
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem_reg[key_wa] <= key_wd;
        if (key_re)
            key_rd_reg <= key_mem_reg[key_ra];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        bidx_reg  <= bidx_next;
        pos_reg   <= pos_next;
        has_r_reg <= has_r_next;
        e_id_reg  <= e_id_next;
        l_id_reg  <= l_id_next;
        r_id_reg  <= r_id_next;
        e_key_reg <= e_key_next;
        l_key_reg <= l_key_next;
        r_key_reg <= r_key_next;
        front_reg <= front_next;
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            present_reg <= '0;
            status_reg  <= ST_OK;
            read_id_reg <= '0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            present_reg <= present_next;
            status_reg  <= status_next;
            read_id_reg <= read_id_next;
        end
    end

    assign rsp.status      = status_reg;
    assign rsp.front_valid = cnt_reg != '0;
    assign rsp.front_id    = (cnt_reg != '0) ? front_reg : 8'd0;
    assign rsp.count       = COUNT_W'(cnt_reg);
    assign rsp.read_id     = read_id_reg;

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= MAX_EDGES)
        else $error("entry count beyond capacity");

    a_present_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.done |-> ($countones(present_reg) == 32'(cnt_reg)))
        else $error("presence bits disagree with entry count");

    a_front_present: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.done && cnt_reg != '0) |-> present_reg[front_reg])
        else $error("front edge not marked present");

endmodule

`default_nettype wire

// ----- design/indexed_edge_min_heap.sv -----
// Indexed binary min-heap of edge ids: one request in, one response out.
// Build runs a sift-down per internal slot. The slot memory has a single read
// port. One request at a time: the next one is taken the cycle after the strobe;
// the strobe lasts one cycle, no stall.
// Reset empties the heap at once; the key and slot memories need no clearing.
`default_nettype none

module indexed_edge_min_heap
    import iemh_pkg::*;
#(
    parameter int MAX_EDGES = MAX_EDGES_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire request_t req,
    output logic          done,
    output response_t     rsp
);

    cmd_t cmd;
    sts_t sts;

    iemh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .sts   (sts),
        .cmd   (cmd)
    );

    iemh_datapath #(
        .MAX_EDGES (MAX_EDGES)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire
